// ----- hw/rtl/lrst_pkg.sv -----
// Shared types, operation codes and node update function for the lazy range sum tree.
package lrst_pkg;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_ASSIGN = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   typedef struct packed {
      logic [63:0] sum;
      logic        asg;
      logic [63:0] amt;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   // apply an add or assign tag to a node that spans 2**sh leaves
   function automatic node_type apply_tag(node_type n, logic asg, logic [63:0] amt,
                                          logic [5:0] sh);
      node_type    r;
      logic [63:0] part;
      part = amt << sh;
      r    = n;
      if (asg) begin
         r.sum = part;
         r.asg = 1'b1;
         r.amt = amt;
      end else begin
         r.sum = n.sum + part;
         r.amt = n.amt + amt;
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/lrst_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module lrst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- hw/rtl/lazy_range_add_assign_sum_tree_top.sv -----
// Lazy segment tree with range add, range assign and range sum over one node RAM.
//
//   channel   ports                                   handshake
//   request   req_op req_lo req_hi req_value          start & !busy
//   response  rsp_range_sum                           rsp_valid, one cycle
//
// One transaction stays busy through boundary pushes top down, the canonical node
// walk, then a sum refresh bottom up (queries skip the refresh), all through the
// single read and single write port of the node RAM; L = log2 of the padded leaf count.
// Empty ranges and the no-op code answer 0 the next cycle without going busy.
// After reset a clearing pass writes all 2**(L+1) nodes, busy meanwhile.
// The receiver cannot stall; each response is on the ports for one cycle.
module lazy_range_add_assign_sum_tree_top #(
   parameter int LEAVES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic [9:0]         req_lo,
   input  logic [10:0]        req_hi,
   input  logic signed [63:0] req_value,
   output logic               rsp_valid,
   output logic signed [63:0] rsp_range_sum
);
   import lrst_pkg::*;

   localparam int L     = $clog2(LEAVES);
   localparam int SPAN  = 1 << L;
   localparam int AW    = L + 1;
   localparam int NW    = L + 2;
   localparam int LW    = $clog2(L + 2);
   localparam int DEPTH = 2 * SPAN;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_PSEL  = 4'd2;
   localparam logic [3:0] ST_P1    = 4'd3;
   localparam logic [3:0] ST_P2    = 4'd4;
   localparam logic [3:0] ST_P3    = 4'd5;
   localparam logic [3:0] ST_P4    = 4'd6;
   localparam logic [3:0] ST_MSEL  = 4'd7;
   localparam logic [3:0] ST_MRD   = 4'd8;
   localparam logic [3:0] ST_USEL  = 4'd9;
   localparam logic [3:0] ST_U1    = 4'd10;
   localparam logic [3:0] ST_U2    = 4'd11;

   logic [3:0]    state_ff;
   logic [AW-1:0] clr_ff;
   logic [1:0]    op_ff;
   logic [63:0]   val_ff;
   logic [NW-1:0] lb_ff, rb_ff, lcur_ff, rcur_ff;
   logic [LW-1:0] lvl_ff;
   logic          side_ff;
   logic [AW-1:0] node_ff;
   node_type      hold_ff;
   logic [63:0]   acc_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [63:0]   rsp_sum_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   node_type      wr_data, rd_data;

   logic [NW-1:0] mask_w, rcur_dec;
   logic          bnd_need;
   logic [AW-1:0] bnd_node;
   logic          push_done, pull_done;
   logic [31:0]   hi_lim;
   logic          req_empty;

   lrst_ram #(.WIDTH(NODE_W), .DEPTH(DEPTH)) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rcur_dec  = rcur_ff - NW'(1);
   assign push_done = side_ff && (lvl_ff == LW'(1));
   assign pull_done = side_ff && (lvl_ff == LW'(L));
   assign hi_lim    = (32'(req_hi) > 32'(LEAVES)) ? 32'(LEAVES) : 32'(req_hi);
   assign req_empty = (32'(req_lo) >= hi_lim) || (req_op == OP_NONE);

   assign rsp_valid_in =
      (state_ff == ST_IDLE && start && req_empty) ||
      (state_ff == ST_MSEL && !side_ff && (lcur_ff >= rcur_ff) && (op_ff == OP_QUERY)) ||
      ((state_ff == ST_U2 || (state_ff == ST_USEL && !bnd_need)) && pull_done);

   // ancestor of the left or right range boundary at the current level
   always_comb begin
      mask_w = (NW'(1) << lvl_ff) - NW'(1);
      if (!side_ff) begin
         bnd_need = |(lb_ff & mask_w);
         bnd_node = AW'(lb_ff >> lvl_ff);
      end else begin
         bnd_need = |(rb_ff & mask_w);
         bnd_node = AW'((rb_ff - NW'(1)) >> lvl_ff);
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = node_ff;
      wr_data = '0;
      rd_addr = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
         end
         ST_PSEL: rd_addr = bnd_node;
         ST_P1:   rd_addr = {node_ff[AW-2:0], 1'b0};
         ST_P2: begin
            wr_en   = 1'b1;
            wr_addr = {node_ff[AW-2:0], 1'b0};
            wr_data = apply_tag(rd_data, hold_ff.asg, hold_ff.amt, 6'(lvl_ff - LW'(1)));
            rd_addr = {node_ff[AW-2:0], 1'b1};
         end
         ST_P3: begin
            wr_en   = 1'b1;
            wr_addr = {node_ff[AW-2:0], 1'b1};
            wr_data = apply_tag(rd_data, hold_ff.asg, hold_ff.amt, 6'(lvl_ff - LW'(1)));
         end
         ST_P4: begin
            wr_en       = 1'b1;
            wr_data.sum = hold_ff.sum;
         end
         ST_MSEL: rd_addr = side_ff ? AW'(rcur_dec) : AW'(lcur_ff);
         ST_MRD: begin
            wr_en   = (op_ff != OP_QUERY);
            wr_data = apply_tag(rd_data, op_ff == OP_ASSIGN, val_ff, 6'(lvl_ff));
         end
         ST_USEL: rd_addr = {bnd_node[AW-2:0], 1'b0};
         ST_U1:   rd_addr = {node_ff[AW-2:0], 1'b1};
         ST_U2: begin
            wr_en       = 1'b1;
            wr_data.sum = hold_ff.sum + rd_data.sum;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (&clr_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  op_ff  <= req_op;
                  val_ff <= req_value;
                  if (req_empty) begin
                     rsp_sum_ff <= '0;
                  end else begin
                     lb_ff    <= NW'(32'(req_lo) + 32'(SPAN));
                     rb_ff    <= NW'(hi_lim + 32'(SPAN));
                     lvl_ff   <= LW'(L);
                     side_ff  <= 1'b0;
                     acc_ff   <= '0;
                     state_ff <= ST_PSEL;
                  end
               end
            end
            ST_PSEL, ST_P4: begin
               if (state_ff == ST_PSEL && bnd_need) begin
                  node_ff  <= bnd_node;
                  state_ff <= ST_P1;
               end else begin
                  side_ff <= !side_ff;
                  if (side_ff) begin
                     lvl_ff <= lvl_ff - LW'(1);
                  end
                  if (push_done) begin
                     lcur_ff  <= lb_ff;
                     rcur_ff  <= rb_ff;
                     state_ff <= ST_MSEL;
                  end else begin
                     state_ff <= ST_PSEL;
                  end
               end
            end
            ST_P1: begin
               hold_ff  <= rd_data;
               state_ff <= ST_P2;
            end
            ST_P2: state_ff <= ST_P3;
            ST_P3: state_ff <= ST_P4;
            ST_MSEL: begin
               if (!side_ff) begin
                  if (lcur_ff >= rcur_ff) begin
                     if (op_ff == OP_QUERY) begin
                        rsp_sum_ff <= acc_ff;
                        state_ff   <= ST_IDLE;
                     end else begin
                        lvl_ff   <= LW'(1);
                        state_ff <= ST_USEL;
                     end
                  end else begin
                     side_ff <= 1'b1;
                     if (lcur_ff[0]) begin
                        node_ff  <= AW'(lcur_ff);
                        lcur_ff  <= lcur_ff + NW'(1);
                        state_ff <= ST_MRD;
                     end
                  end
               end else begin
                  side_ff <= 1'b0;
                  lcur_ff <= lcur_ff >> 1;
                  rcur_ff <= (rcur_ff[0] ? rcur_dec : rcur_ff) >> 1;
                  if (rcur_ff[0]) begin
                     node_ff  <= AW'(rcur_dec);
                     state_ff <= ST_MRD;
                  end else begin
                     lvl_ff <= lvl_ff + LW'(1);
                  end
               end
            end
            ST_MRD: begin
               if (op_ff == OP_QUERY) begin
                  acc_ff <= acc_ff + rd_data.sum;
               end
               // right-side node done: step up a level
               if (!side_ff) begin
                  lvl_ff <= lvl_ff + LW'(1);
               end
               state_ff <= ST_MSEL;
            end
            ST_USEL, ST_U2: begin
               if (state_ff == ST_USEL && bnd_need) begin
                  node_ff  <= bnd_node;
                  state_ff <= ST_U1;
               end else begin
                  side_ff <= !side_ff;
                  if (pull_done) begin
                     rsp_sum_ff <= '0;
                     state_ff   <= ST_IDLE;
                  end else begin
                     if (side_ff) begin
                        lvl_ff <= lvl_ff + LW'(1);
                     end
                     state_ff <= ST_USEL;
                  end
               end
            end
            ST_U1: begin
               hold_ff  <= rd_data;
               state_ff <= ST_U2;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;

`ifndef SYNTHESIS
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted transaction neither started nor answered");

   a_update_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && op_ff != OP_QUERY |-> rsp_range_sum == 64'sd0)
      else $error("nonzero response for a non-query transaction");

   a_clear_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid)
      else $error("response during clearing pass");
`endif

endmodule
